FILE: rtl/smlsu_pkg.sv
// Shared types and constants for the string move/load/store unit.
// Used by string_move_load_store_unit and its testbench.
package smlsu_pkg;

	localparam int MEM_BYTES_DEF = 4096;

	localparam logic [2:0] OP_HOST_WR = 3'd0;
	localparam logic [2:0] OP_HOST_RD = 3'd1;
	localparam logic [2:0] OP_LODS    = 3'd2;
	localparam logic [2:0] OP_MOVS    = 3'd3;
	localparam logic [2:0] OP_STOS    = 3'd4;

	localparam logic [1:0] SIZE_RSVD  = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [1:0]  elem_size_code;
		logic        repeat_req;
		logic        direction;
		logic [31:0] src_index;
		logic [31:0] dst_index;
		logic [31:0] count;
		logic [31:0] accum;
	} cmd_t;

	typedef struct packed {
		logic [31:0] new_src_index;
		logic [31:0] new_dst_index;
		logic [31:0] new_count;
		logic [31:0] new_accum;
		logic [7:0]  read_byte;
		logic        status;
	} rsp_t;

endpackage

FILE: rtl/string_move_load_store_unit.sv
// String move/load/store unit: sequencer around one byte memory.
// Depends on smlsu_pkg and smlsu_bytemem.
//
// channel   direction  handshake              payload
// command   in         start & !busy          cmd  (smlsu_pkg::cmd_t)
// result    out        done, one cycle        rsp  (smlsu_pkg::rsp_t)
//
// Steps: CHK, then HRD for a host read, then FIN. String ops take each element
// through RD and RDL (load), RD, RDL and WR (move) or WR (store), one byte at a
// time via the single byte port. After reset a clearing pass zeroes every byte
// with busy high. The receiver cannot stall; done is one-cycle.
module string_move_load_store_unit #(
	parameter int MEM_BYTES = smlsu_pkg::MEM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  smlsu_pkg::cmd_t  cmd,
	output logic             done,
	output smlsu_pkg::rsp_t  rsp
);

	localparam int AW = $clog2(MEM_BYTES);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_HRD  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_RDL  = 3'd5;
	localparam logic [2:0] ST_WR   = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]      state_q;
	logic [AW-1:0]   clr_q;
	smlsu_pkg::cmd_t in_q;
	logic [31:0]     a_q, b_q, acc_q, cnt_q, rem_q;
	logic [7:0]      rb_q;
	logic            fault_q;
	logic [1:0]      bi_q, pidx_q;
	logic            pend_q;
	logic [7:0]      buf_q [4];

	logic            we;
	logic [AW-1:0]   waddr, raddr;
	logic [7:0]      wdata, rdata;

	function automatic logic walk_ok(input logic [31:0] a, input logic [1:0] code,
		input logic [31:0] n, input logic down);
		logic [33:0] span, lim, a34;
		span = {2'b00, n - 32'd1} << code;
		lim  = 34'(MEM_BYTES) - (34'd1 << code);
		a34  = {2'b00, a};
		return (a34 <= lim) && (down ? (a34 >= span) : (a34 + span <= lim));
	endfunction

	// decode of the held command
	logic        use_src, use_dst, is_str, host_ok;
	logic [31:0] n_c, step_c, mask_c;
	logic [1:0]  sm1_c;
	logic [31:0] elem_c;

	always_comb begin
		is_str  = in_q.operation inside {smlsu_pkg::OP_LODS, smlsu_pkg::OP_MOVS,
			smlsu_pkg::OP_STOS};
		use_src = in_q.operation != smlsu_pkg::OP_STOS;
		use_dst = in_q.operation != smlsu_pkg::OP_LODS;
		host_ok = {1'b0, in_q.dst_index} < 33'(MEM_BYTES);
		n_c     = in_q.repeat_req ? in_q.count : 32'd1;
		step_c  = 32'd1 << in_q.elem_size_code;
		case (in_q.elem_size_code)
			2'd0:    begin sm1_c = 2'd0; mask_c = 32'h0000_00ff; end
			2'd1:    begin sm1_c = 2'd1; mask_c = 32'h0000_ffff; end
			default: begin sm1_c = 2'd3; mask_c = 32'hffff_ffff; end
		endcase
		elem_c = {buf_q[3], buf_q[2], buf_q[1], buf_q[0]};
		case (pidx_q)
			2'd0:    elem_c[7:0]   = rdata;
			2'd1:    elem_c[15:8]  = rdata;
			2'd2:    elem_c[23:16] = rdata;
			default: elem_c[31:24] = rdata;
		endcase
	end

	// memory port steering
	always_comb begin
		we    = 1'b0;
		waddr = b_q[AW-1:0] + AW'(bi_q);
		wdata = (in_q.operation == smlsu_pkg::OP_STOS) ? 8'(in_q.accum >> {bi_q, 3'b000})
			: buf_q[bi_q];
		raddr = a_q[AW-1:0] + AW'(bi_q);
		case (state_q)
			ST_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = 8'h00;
			end
			ST_CHK: begin
				raddr = in_q.dst_index[AW-1:0];
				waddr = in_q.dst_index[AW-1:0];
				wdata = in_q.accum[7:0];
				we    = (in_q.operation == smlsu_pkg::OP_HOST_WR) && host_ok;
			end
			ST_WR:   we = 1'b1;
			default: we = 1'b0;
		endcase
	end

	smlsu_bytemem #(.MEM_BYTES(MEM_BYTES), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// element done: step indices, maybe finish
	logic last_elem;
	assign last_elem = rem_q == 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			pend_q  <= 1'b0;
			bi_q    <= 2'd0;
		end else begin
			pend_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MEM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					bi_q <= 2'd0;
					if (in_q.operation == smlsu_pkg::OP_HOST_RD && host_ok) begin
						state_q <= ST_HRD;
					end else if (is_str && in_q.elem_size_code != smlsu_pkg::SIZE_RSVD
						&& n_c != 32'd0 && !((use_src && !walk_ok(in_q.src_index,
						in_q.elem_size_code, n_c, in_q.direction)) || (use_dst &&
						!walk_ok(in_q.dst_index, in_q.elem_size_code, n_c,
						in_q.direction)))) begin
						state_q <= (in_q.operation == smlsu_pkg::OP_STOS) ? ST_WR : ST_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_HRD: state_q <= ST_FIN;
				ST_RD: begin
					pend_q <= 1'b1;
					if (bi_q == sm1_c) begin
						bi_q    <= 2'd0;
						state_q <= ST_RDL;
					end else begin
						bi_q <= bi_q + 2'd1;
					end
				end
				ST_RDL: begin
					if (in_q.operation == smlsu_pkg::OP_MOVS) begin
						state_q <= ST_WR;
					end else begin
						state_q <= last_elem ? ST_FIN : ST_RD;
					end
				end
				ST_WR: begin
					if (bi_q == sm1_c) begin
						bi_q <= 2'd0;
						if (last_elem) begin
							state_q <= ST_FIN;
						end else begin
							state_q <= (in_q.operation == smlsu_pkg::OP_STOS) ? ST_WR : ST_RD;
						end
					end else begin
						bi_q <= bi_q + 2'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	logic elem_end;
	assign elem_end = (state_q == ST_RDL && in_q.operation == smlsu_pkg::OP_LODS) ||
		(state_q == ST_WR && bi_q == sm1_c);

	always_ff @(posedge clk) begin
		pidx_q <= bi_q;
		if (pend_q) begin
			buf_q[pidx_q] <= rdata;
		end
		if (state_q == ST_IDLE && start) begin
			in_q <= cmd;
		end
		if (state_q == ST_CHK) begin
			a_q     <= in_q.src_index;
			b_q     <= in_q.dst_index;
			acc_q   <= in_q.accum;
			rem_q   <= n_c;
			rb_q    <= 8'h00;
			cnt_q   <= in_q.count;
			fault_q <= 1'b0;
			if (in_q.operation inside {smlsu_pkg::OP_HOST_WR, smlsu_pkg::OP_HOST_RD}) begin
				fault_q <= !host_ok;
			end else if (is_str) begin
				if (in_q.elem_size_code == smlsu_pkg::SIZE_RSVD || (n_c != 32'd0 &&
					((use_src && !walk_ok(in_q.src_index, in_q.elem_size_code, n_c,
					in_q.direction)) || (use_dst && !walk_ok(in_q.dst_index,
					in_q.elem_size_code, n_c, in_q.direction))))) begin
					fault_q <= 1'b1;
				end else if (in_q.repeat_req) begin
					cnt_q <= 32'd0;
				end
			end
		end
		if (state_q == ST_HRD) begin
			rb_q <= rdata;
		end
		if (state_q == ST_RDL && in_q.operation == smlsu_pkg::OP_LODS) begin
			acc_q <= (acc_q & ~mask_c) | (elem_c & mask_c);
		end
		if (elem_end) begin
			rem_q <= rem_q - 32'd1;
			if (use_src) begin
				a_q <= in_q.direction ? a_q - step_c : a_q + step_c;
			end
			if (use_dst) begin
				b_q <= in_q.direction ? b_q - step_c : b_q + step_c;
			end
		end
	end

	assign busy = state_q != ST_IDLE;
	assign done = state_q == ST_FIN;

	always_comb begin
		rsp.new_src_index = a_q;
		rsp.new_dst_index = b_q;
		rsp.new_count     = cnt_q;
		rsp.new_accum     = acc_q;
		rsp.read_byte     = rb_q;
		rsp.status        = fault_q;
	end

endmodule

FILE: rtl/smlsu_bytemem.sv
// Byte-wide data memory, one write and one registered read port.
// Depends on nothing beyond its parameters.
module smlsu_bytemem #(
	parameter int MEM_BYTES = 4096,
	parameter int AW = $clog2(MEM_BYTES)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [MEM_BYTES];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/string_move_load_store_unit_test.sv
// Self-checking testbench for string_move_load_store_unit.
// Runs directed and random string and host commands through its own byte-memory
// predictor; needs smlsu_pkg and the RTL only.
module string_move_load_store_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH_BYTES = smlsu_pkg::MEM_BYTES_DEF;
	localparam int N_RANDOM = 480;
	localparam longint CYCLE_LIMIT = 20000000;
	localparam logic [2:0] OP_RSVD_LO = 3'd5;
	localparam logic [2:0] OP_RSVD_HI = 3'd7;

	typedef struct {
		smlsu_pkg::cmd_t c;
		bit   typed;
		smlsu_pkg::rsp_t e;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	smlsu_pkg::cmd_t cmd = '0;
	smlsu_pkg::rsp_t rsp;

	logic [7:0] mem_image [DEPTH_BYTES];
	smlsu_pkg::rsp_t expected_words [$];
	stim_row_t directed [$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int faults_seen = 0;
	longint cycles = 0;

	string_move_load_store_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// every element a0 +/- k*s (k < n) lies wholly in memory
	function automatic bit walk_ok(logic [31:0] a0, int s, longint n, bit down);
		longint lim;
		longint span;
		lim = DEPTH_BYTES - s;
		span = (n - 1) * s;
		if (longint'(a0) > lim) return 0;
		if (down) return longint'(a0) >= span;
		return longint'(a0) + span <= lim;
	endfunction

	function automatic smlsu_pkg::rsp_t passthru(smlsu_pkg::cmd_t c, logic [7:0] rb, logic st);
		smlsu_pkg::rsp_t r;
		r.new_src_index = c.src_index;
		r.new_dst_index = c.dst_index;
		r.new_count = c.count;
		r.new_accum = c.accum;
		r.read_byte = rb;
		r.status = st;
		return r;
	endfunction

	// updates mem_image and returns the word the unit should answer with
	function automatic smlsu_pkg::rsp_t execute_string_op(smlsu_pkg::cmd_t c);
		smlsu_pkg::rsp_t r;
		int s;
		longint n;
		longint k;
		bit use_src;
		bit use_dst;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] step;
		logic [31:0] v;
		r = passthru(c, 8'd0, 1'b0);
		if (c.operation == smlsu_pkg::OP_HOST_WR || c.operation == smlsu_pkg::OP_HOST_RD) begin
			if (c.dst_index >= DEPTH_BYTES) r.status = 1'b1;
			else if (c.operation == smlsu_pkg::OP_HOST_WR) mem_image[c.dst_index] = c.accum[7:0];
			else r.read_byte = mem_image[c.dst_index];
		end else if (c.operation <= smlsu_pkg::OP_STOS) begin
			s = 1 << c.elem_size_code;
			n = c.repeat_req ? longint'(c.count) : 1;
			use_src = c.operation != smlsu_pkg::OP_STOS;
			use_dst = c.operation != smlsu_pkg::OP_LODS;
			if (c.elem_size_code == smlsu_pkg::SIZE_RSVD) begin
				r.status = 1'b1;
			end else if (n != 0) begin
				if ((use_src && !walk_ok(c.src_index, s, n, c.direction)) ||
				    (use_dst && !walk_ok(c.dst_index, s, n, c.direction))) begin
					r.status = 1'b1;
				end else begin
					step = c.direction ? -s : s;
					a = c.src_index;
					b = c.dst_index;
					for (k = 0; k < n; k++) begin
						v = (c.operation == smlsu_pkg::OP_STOS) ? c.accum : 32'd0;
						if (use_src)
							for (int i = 0; i < s; i++) v[8*i +: 8] = mem_image[a + i];
						if (c.operation == smlsu_pkg::OP_LODS)
							for (int i = 0; i < s; i++) r.new_accum[8*i +: 8] = v[8*i +: 8];
						else
							for (int i = 0; i < s; i++) mem_image[b + i] = v[8*i +: 8];
						a += step;
						b += step;
					end
					if (use_src) r.new_src_index = a;
					if (use_dst) r.new_dst_index = b;
				end
			end
			if (c.repeat_req && !r.status) r.new_count = 32'd0;
		end
		if (r.status) r = passthru(c, 8'd0, 1'b1);
		return r;
	endfunction

	// results are stable at the falling edge and are checked there
	always @(negedge clk) begin
		smlsu_pkg::rsp_t e;
		if (arst_n && done) begin
			if (expected_words.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_words.pop_front();
				words_checked++;
				if (rsp.status) faults_seen++;
				if (rsp.new_src_index !== e.new_src_index) begin
					$error("new_src_index exp %h got %h", e.new_src_index, rsp.new_src_index);
					errors++;
				end
				if (rsp.new_dst_index !== e.new_dst_index) begin
					$error("new_dst_index exp %h got %h", e.new_dst_index, rsp.new_dst_index);
					errors++;
				end
				if (rsp.new_count !== e.new_count) begin
					$error("new_count exp %h got %h", e.new_count, rsp.new_count);
					errors++;
				end
				if (rsp.new_accum !== e.new_accum) begin
					$error("new_accum exp %h got %h", e.new_accum, rsp.new_accum);
					errors++;
				end
				if (rsp.read_byte !== e.read_byte) begin
					$error("read_byte exp %h got %h", e.read_byte, rsp.read_byte);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$error("status exp %b got %b", e.status, rsp.status);
					errors++;
				end
			end
		end
	end

	function automatic smlsu_pkg::cmd_t mk(logic [2:0] op, logic [1:0] sz, bit rep, bit dn,
			logic [31:0] src, logic [31:0] dst, logic [31:0] cnt, logic [31:0] acc);
		smlsu_pkg::cmd_t c;
		c.operation = op;
		c.elem_size_code = sz;
		c.repeat_req = rep;
		c.direction = dn;
		c.src_index = src;
		c.dst_index = dst;
		c.count = cnt;
		c.accum = acc;
		return c;
	endfunction

	task automatic add_row(smlsu_pkg::cmd_t c, bit typed, smlsu_pkg::rsp_t e);
		stim_row_t row;
		row.c = c;
		row.typed = typed;
		row.e = e;
		directed.push_back(row);
	endtask

	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) return $urandom_range(0, DEPTH_BYTES - 1);
		if (r < 85) return $urandom_range(DEPTH_BYTES - 16, DEPTH_BYTES - 1);
		if (r < 92) return $urandom_range(0, 15);
		return $urandom;
	endfunction

	function automatic smlsu_pkg::cmd_t random_cmd();
		smlsu_pkg::cmd_t c;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) c.operation = smlsu_pkg::OP_HOST_WR;
		else if (r < 18) c.operation = smlsu_pkg::OP_HOST_RD;
		else if (r < 45) c.operation = smlsu_pkg::OP_MOVS;
		else if (r < 68) c.operation = smlsu_pkg::OP_LODS;
		else if (r < 94) c.operation = smlsu_pkg::OP_STOS;
		else c.operation = 3'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
		c.elem_size_code = ($urandom_range(0, 19) == 0) ? smlsu_pkg::SIZE_RSVD
			: 2'($urandom_range(0, 2));
		c.repeat_req = 1'($urandom_range(0, 1));
		c.direction = 1'($urandom_range(0, 1));
		c.src_index = pick_addr();
		c.dst_index = pick_addr();
		r = $urandom_range(0, 99);
		if (!c.repeat_req || r < 5) c.count = $urandom;
		else if (r < 75) c.count = $urandom_range(0, 12);
		else if (r < 97) c.count = $urandom_range(13, 64);
		else c.count = $urandom_range(200, 1024);
		c.accum = $urandom;
		return c;
	endfunction

	// holds start until the unit takes the word; busy is decoded from the state register
	task automatic send_word(smlsu_pkg::cmd_t c, smlsu_pkg::rsp_t e);
		start <= 1'b1;
		cmd <= c;
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		expected_words.push_back(e);
		words_sent++;
	endtask

	task automatic maybe_gap();
		int r;
		int g;
		r = $urandom_range(0, 99);
		g = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	initial begin
		smlsu_pkg::rsp_t e;
		int waited;
		foreach (mem_image[i]) mem_image[i] = 8'd0;

		add_row(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'h0, 32'h5, 32'h11), 1,
			passthru(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'h0, 32'h5, 32'h11),
			8'h00, 1'b0));
		add_row(mk(smlsu_pkg::OP_HOST_RD, 2'd3, 1, 1, 32'hFFFF_FFFF, 32'd4095, 32'hFFFF_FFFF,
			32'hFFFF_FFFF), 1, passthru(mk(smlsu_pkg::OP_HOST_RD, 2'd3, 1, 1, 32'hFFFF_FFFF,
			32'd4095, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 8'h00, 1'b0));
		add_row(mk(smlsu_pkg::OP_HOST_WR, 2'd0, 0, 0, 32'h0, 32'd4096, 32'h0, 32'hAB), 1,
			passthru(mk(smlsu_pkg::OP_HOST_WR, 2'd0, 0, 0, 32'h0, 32'd4096, 32'h0, 32'hAB),
			8'h00, 1'b1));
		add_row(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0), 1,
			passthru(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0),
			8'h00, 1'b1));
		add_row(mk(smlsu_pkg::OP_MOVS, smlsu_pkg::SIZE_RSVD, 0, 0, 32'h10, 32'h20, 32'h3,
			32'h1), 1, passthru(mk(smlsu_pkg::OP_MOVS, smlsu_pkg::SIZE_RSVD, 0, 0, 32'h10,
			32'h20, 32'h3, 32'h1), 8'h00, 1'b1));
		add_row(mk(OP_RSVD_HI, 2'd2, 1, 1, 32'hDEAD_BEEF, 32'h1234, 32'h9, 32'h5A5A_A5A5), 1,
			passthru(mk(OP_RSVD_HI, 2'd2, 1, 1, 32'hDEAD_BEEF, 32'h1234, 32'h9,
			32'h5A5A_A5A5), 8'h00, 1'b0));
		add_row(mk(OP_RSVD_LO, 2'd0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0), 1,
			passthru(mk(OP_RSVD_LO, 2'd0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0), 8'h00, 1'b0));
		add_row(mk(smlsu_pkg::OP_HOST_WR, 2'd0, 0, 0, 32'h0, 32'd4095, 32'h0, 32'h1234_56FF),
			0, e);
		add_row(mk(smlsu_pkg::OP_HOST_WR, 2'd0, 0, 0, 32'h0, 32'h0, 32'h0, 32'hAB), 0, e);
		add_row(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'd4095, 32'h0, 32'h0), 0, e);
		// zero count under repeat: nothing touched, count cleared
		add_row(mk(smlsu_pkg::OP_STOS, 2'd2, 1, 0, 32'h0, 32'hFFFF_FFF0, 32'h0, 32'h1), 0, e);
		add_row(mk(smlsu_pkg::OP_STOS, 2'd2, 0, 0, 32'h0, 32'd4092, 32'h7, 32'hCAFE_F00D),
			0, e);
		add_row(mk(smlsu_pkg::OP_LODS, 2'd2, 0, 1, 32'd4092, 32'h0, 32'h0, 32'h0), 0, e);
		add_row(mk(smlsu_pkg::OP_LODS, 2'd1, 0, 0, 32'd4094, 32'h0, 32'h0, 32'hFFFF_FFFF),
			0, e);
		add_row(mk(smlsu_pkg::OP_STOS, 2'd2, 0, 0, 32'h0, 32'd4093, 32'h0, 32'h1), 0, e);
		add_row(mk(smlsu_pkg::OP_STOS, 2'd0, 1, 0, 32'h0, 32'h100, 32'd8, 32'h77), 0, e);
		// overlapping forward move replicates the first byte
		add_row(mk(smlsu_pkg::OP_MOVS, 2'd0, 1, 0, 32'h100, 32'h101, 32'd6, 32'h0), 0, e);
		add_row(mk(smlsu_pkg::OP_MOVS, 2'd1, 1, 1, 32'h106, 32'h108, 32'd4, 32'h0), 0, e);
		add_row(mk(smlsu_pkg::OP_LODS, 2'd0, 1, 1, 32'h107, 32'h0, 32'd3, 32'h1111_1111),
			0, e);
		// walk below zero going down
		add_row(mk(smlsu_pkg::OP_LODS, 2'd1, 1, 1, 32'h2, 32'h0, 32'd3, 32'h0), 0, e);
		add_row(mk(smlsu_pkg::OP_MOVS, 2'd2, 1, 0, 32'h0, 32'd4088, 32'd3, 32'h0), 0, e);
		add_row(mk(smlsu_pkg::OP_MOVS, 2'd2, 1, 0, 32'h0, 32'hF00, 32'hFFFF_FFFF, 32'h0),
			0, e);
		add_row(mk(smlsu_pkg::OP_HOST_RD, 2'd0, 0, 0, 32'h0, 32'h103, 32'h0, 32'h0), 0, e);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			e = execute_string_op(directed[i].c);
			send_word(directed[i].c, directed[i].typed ? directed[i].e : e);
			maybe_gap();
		end
		for (int i = 0; i < N_RANDOM; i++) begin
			smlsu_pkg::cmd_t c;
			c = random_cmd();
			send_word(c, execute_string_op(c));
			if (i % 100 < 70) maybe_gap();
		end
		start <= 1'b0;

		waited = 0;
		while (expected_words.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (expected_words.size() != 0) begin
			$error("%0d result words never arrived", expected_words.size());
			errors++;
		end
		$display("%0d command words sent, %0d results checked, %0d of them faults",
			words_sent, words_checked, faults_seen);
		$display("covered host access, string load/move/store, repeat, both directions");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
